// ===== src/packet_header_sequence_monitor_core_assert.svh =====
// Assertion macros for the packet header sequence monitor.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PACKET_HEADER_SEQUENCE_MONITOR_CORE_ASSERT_SVH
`define PACKET_HEADER_SEQUENCE_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PHSM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PHSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/phsm_pkg.sv =====
// Package for the packet header sequence monitor: codes, constants, helpers.
// Depends on nothing; imported by packet_header_sequence_monitor_core.
package phsm_pkg;

    // Header search and packet layout
    localparam int          HEADER_SEARCH_SPAN = 10;
    localparam logic [7:0]  SYNC_BYTE          = 8'hBB;
    localparam logic [7:0]  TYPE_ADC           = 8'hD0;
    localparam logic [7:0]  TYPE_FFT           = 8'hD1;
    localparam logic [15:0] SEQ_DISTANCE       = 16'd3;
    localparam logic [15:0] POS_MAX            = 16'hFFFF;
    localparam logic [31:0] CNT_MAX            = 32'hFFFF_FFFF;
    localparam logic [15:0] EXP_LENGTH_RESET   = 16'd1024;

    // Input item mode
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Result item kind
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_ADC_OK     = 2'd0,
        VERDICT_FFT_OK     = 2'd1,
        VERDICT_BAD_LENGTH = 2'd2,
        VERDICT_BAD_HEADER = 2'd3
    } verdict_t;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? CNT_MAX : sum[31:0];
    endfunction

endpackage

// ===== src/packet_header_sequence_monitor_core.sv =====
// Packet header and sequence monitor: header search, length check, gap counters.
// Depends on phsm_pkg and packet_header_sequence_monitor_core_assert.svh.
//
//  Channel  Prefix  Direction  Moves
//  -------  ------  ---------  ---------------------------------------------
//  input    s_      in         one packet byte or one report request
//  result   m_      out        one packet verdict or one counter report
//  config   cfg_    in         expected packet length (always ready)
//
// One item per cycle while s_ready is high: each byte is folded into the packet state in the cycle
// it is accepted, and a result lands in the output register in the cycle after.
// Reset (synchronous, active low) clears all packet state, the sequence
// tracker and the counters, and loads an expected length of 1024.
// A stalled output holds s_ready low only while a result is waiting and
// m_ready is low; a taken result frees the register in the same cycle.
`include "packet_header_sequence_monitor_core_assert.svh"

module packet_header_sequence_monitor_core
    import phsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [1:0]  m_verdict,
    output logic [7:0]  m_seq_gap,
    output logic [31:0] m_loss_events,
    output logic [31:0] m_lost_total,
    output logic [31:0] m_bad_header_count,
    output logic [31:0] m_bad_length_count
);

    // Configuration and packet state
    logic [15:0] expected_length_reg;
    logic [15:0] byte_position_reg,     byte_position_next;
    logic [7:0]  previous_byte_reg,     previous_byte_next;
    logic        header_found_reg,      header_found_next;
    logic [3:0]  header_offset_reg,     header_offset_next;
    logic        packet_is_fft_reg,     packet_is_fft_next;
    logic [7:0]  captured_sequence_reg, captured_sequence_next;
    logic        sequence_started_reg,  sequence_started_next;
    logic [7:0]  expected_sequence_reg, expected_sequence_next;
    logic [31:0] loss_event_cnt_reg,    loss_event_cnt_next;
    logic [31:0] lost_packet_cnt_reg,   lost_packet_cnt_next;
    logic [31:0] bad_header_cnt_reg,    bad_header_cnt_next;
    logic [31:0] bad_length_cnt_reg,    bad_length_cnt_next;

    // Output register
    logic        m_valid_reg,           m_valid_next;
    logic        out_kind_reg,          out_kind_next;
    verdict_t    out_verdict_reg,       out_verdict_next;
    logic [7:0]  out_gap_reg,           out_gap_next;
    logic [31:0] out_loss_reg,          out_loss_next;
    logic [31:0] out_lost_reg,          out_lost_next;
    logic [31:0] out_bad_hdr_reg,       out_bad_hdr_next;
    logic [31:0] out_bad_len_reg,       out_bad_len_next;

    // Per-byte decode
    logic        s_accept;
    logic [15:0] pos_m1;
    logic        hdr_hit;
    logic        hdr_found_upd;
    logic [3:0]  hdr_offset_upd;
    logic        is_fft_upd;
    logic [15:0] seq_pos;
    logic [7:0]  seq_upd;
    logic        seq_present;
    logic        len_bad;
    logic        seq_mismatch;
    logic [7:0]  gap;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    // Header search, sequence capture and end-of-packet checks
    always_comb begin
        pos_m1         = byte_position_reg - 16'd1;
        hdr_hit        = !header_found_reg
                         && (byte_position_reg >= 16'd1)
                         && (byte_position_reg <= 16'(HEADER_SEARCH_SPAN))
                         && (previous_byte_reg == SYNC_BYTE)
                         && ((s_data_byte == TYPE_ADC) || (s_data_byte == TYPE_FFT));
        hdr_found_upd  = header_found_reg || hdr_hit;
        hdr_offset_upd = hdr_hit ? pos_m1[3:0] : header_offset_reg;
        is_fft_upd     = hdr_hit ? (s_data_byte == TYPE_FFT) : packet_is_fft_reg;
        seq_pos        = {12'd0, hdr_offset_upd} + SEQ_DISTANCE;
        seq_upd        = (hdr_found_upd && (byte_position_reg == seq_pos))
                         ? s_data_byte : captured_sequence_reg;
        seq_present    = hdr_found_upd && (byte_position_reg >= seq_pos);
        len_bad        = (byte_position_reg == POS_MAX)
                         || (({1'b0, byte_position_reg} + 17'd1)
                             != {1'b0, expected_length_reg});
        seq_mismatch   = sequence_started_reg && (seq_upd != expected_sequence_reg);
        gap            = seq_upd - expected_sequence_reg;
    end

    // Next-state logic for one accepted item
    always_comb begin
        byte_position_next     = byte_position_reg;
        previous_byte_next     = previous_byte_reg;
        header_found_next      = header_found_reg;
        header_offset_next     = header_offset_reg;
        packet_is_fft_next     = packet_is_fft_reg;
        captured_sequence_next = captured_sequence_reg;
        sequence_started_next  = sequence_started_reg;
        expected_sequence_next = expected_sequence_reg;
        loss_event_cnt_next    = loss_event_cnt_reg;
        lost_packet_cnt_next   = lost_packet_cnt_reg;
        bad_header_cnt_next    = bad_header_cnt_reg;
        bad_length_cnt_next    = bad_length_cnt_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_verdict_next = out_verdict_reg;
        out_gap_next     = out_gap_reg;
        out_loss_next    = out_loss_reg;
        out_lost_next    = out_lost_reg;
        out_bad_hdr_next = out_bad_hdr_reg;
        out_bad_len_next = out_bad_len_reg;

        if (s_accept) begin
            if (s_mode == MODE_REPORT) begin
                // report and clear the counters; packet in progress untouched
                m_valid_next         = 1'b1;
                out_kind_next        = KIND_REPORT;
                out_verdict_next     = VERDICT_ADC_OK;
                out_gap_next         = 8'd0;
                out_loss_next        = loss_event_cnt_reg;
                out_lost_next        = lost_packet_cnt_reg;
                out_bad_hdr_next     = bad_header_cnt_reg;
                out_bad_len_next     = bad_length_cnt_reg;
                loss_event_cnt_next  = 32'd0;
                lost_packet_cnt_next = 32'd0;
                bad_header_cnt_next  = 32'd0;
                bad_length_cnt_next  = 32'd0;
            end else if (!s_last_byte) begin
                // mid-packet byte: update the search state
                previous_byte_next     = s_data_byte;
                header_found_next      = hdr_found_upd;
                header_offset_next     = hdr_offset_upd;
                packet_is_fft_next     = is_fft_upd;
                captured_sequence_next = seq_upd;
                if (byte_position_reg != POS_MAX) begin
                    byte_position_next = byte_position_reg + 16'd1;
                end
            end else begin
                // last byte: verdict, counters, then clear the packet state
                m_valid_next     = 1'b1;
                out_kind_next    = KIND_VERDICT;
                out_gap_next     = 8'd0;
                out_loss_next    = 32'd0;
                out_lost_next    = 32'd0;
                out_bad_hdr_next = 32'd0;
                out_bad_len_next = 32'd0;
                if (len_bad) begin
                    out_verdict_next    = VERDICT_BAD_LENGTH;
                    bad_length_cnt_next = sat_add(bad_length_cnt_reg, 32'd1);
                end else if (!seq_present) begin
                    out_verdict_next    = VERDICT_BAD_HEADER;
                    bad_header_cnt_next = sat_add(bad_header_cnt_reg, 32'd1);
                end else begin
                    out_verdict_next = is_fft_upd ? VERDICT_FFT_OK : VERDICT_ADC_OK;
                    if (seq_mismatch) begin
                        out_gap_next         = gap;
                        lost_packet_cnt_next = sat_add(lost_packet_cnt_reg, {24'd0, gap});
                        loss_event_cnt_next  = sat_add(loss_event_cnt_reg, 32'd1);
                    end
                    sequence_started_next  = 1'b1;
                    expected_sequence_next = seq_upd + 8'd1;
                end
                byte_position_next     = 16'd0;
                previous_byte_next     = 8'd0;
                header_found_next      = 1'b0;
                header_offset_next     = 4'd0;
                packet_is_fft_next     = 1'b0;
                captured_sequence_next = 8'd0;
            end
        end
    end

    // Control state, counters and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_length_reg   <= EXP_LENGTH_RESET;
            byte_position_reg     <= 16'd0;
            previous_byte_reg     <= 8'd0;
            header_found_reg      <= 1'b0;
            header_offset_reg     <= 4'd0;
            packet_is_fft_reg     <= 1'b0;
            captured_sequence_reg <= 8'd0;
            sequence_started_reg  <= 1'b0;
            expected_sequence_reg <= 8'd0;
            loss_event_cnt_reg    <= 32'd0;
            lost_packet_cnt_reg   <= 32'd0;
            bad_header_cnt_reg    <= 32'd0;
            bad_length_cnt_reg    <= 32'd0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                expected_length_reg <= cfg_data;
            end
            byte_position_reg     <= byte_position_next;
            previous_byte_reg     <= previous_byte_next;
            header_found_reg      <= header_found_next;
            header_offset_reg     <= header_offset_next;
            packet_is_fft_reg     <= packet_is_fft_next;
            captured_sequence_reg <= captured_sequence_next;
            sequence_started_reg  <= sequence_started_next;
            expected_sequence_reg <= expected_sequence_next;
            loss_event_cnt_reg    <= loss_event_cnt_next;
            lost_packet_cnt_reg   <= lost_packet_cnt_next;
            bad_header_cnt_reg    <= bad_header_cnt_next;
            bad_length_cnt_reg    <= bad_length_cnt_next;
            m_valid_reg           <= m_valid_next;
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        out_kind_reg    <= out_kind_next;
        out_verdict_reg <= out_verdict_next;
        out_gap_reg     <= out_gap_next;
        out_loss_reg    <= out_loss_next;
        out_lost_reg    <= out_lost_next;
        out_bad_hdr_reg <= out_bad_hdr_next;
        out_bad_len_reg <= out_bad_len_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_result_kind      = out_kind_reg;
    assign m_verdict          = out_verdict_reg;
    assign m_seq_gap          = out_gap_reg;
    assign m_loss_events      = out_loss_reg;
    assign m_lost_total       = out_lost_reg;
    assign m_bad_header_count = out_bad_hdr_reg;
    assign m_bad_length_count = out_bad_len_reg;

    // Assertions
    `PHSM_ASSERT_NEXT(a_report_clears, aclk, aresetn, s_accept && (s_mode == MODE_REPORT), (loss_event_cnt_reg == 32'd0) && (lost_packet_cnt_reg == 32'd0) && (bad_header_cnt_reg == 32'd0) && (bad_length_cnt_reg == 32'd0), "counters not cleared after report")
    `PHSM_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept && ((s_mode == MODE_REPORT) || s_last_byte), m_valid, "no result after report or last byte")
    `PHSM_ASSERT_NEXT(a_no_spurious, aclk, aresetn, s_accept && (s_mode == MODE_PACKET) && !s_last_byte, !m_valid, "result produced for a mid-packet byte")
    `PHSM_ASSERT_NEXT(a_packet_cleared, aclk, aresetn, s_accept && (s_mode == MODE_PACKET) && s_last_byte, (byte_position_reg == 16'd0) && !header_found_reg, "packet state not cleared at end of packet")
    `PHSM_ASSERT_NOW(a_offset_range, aclk, aresetn, header_found_reg, header_offset_reg < 4'(HEADER_SEARCH_SPAN), "header offset outside search span")

endmodule
